@@ rtl/rc_pulse_capture_filter_top_assert.svh @@
// Assertion macros for the RC pulse capture filter.
`ifndef RC_PULSE_CAPTURE_FILTER_TOP_ASSERT_SVH
`define RC_PULSE_CAPTURE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RCPCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rc_pulse_capture_filter: assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define RCPCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rc_pulse_capture_filter: assertion failed");

`endif

@@ rtl/rcpcf_pkg.sv @@
package rcpcf_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int LPF_W      = COUNT_BITS + FRAC_BITS;
  localparam int ALPHA_W    = 16;
  localparam int BASE_W     = 12;
  localparam int SPAN_W     = 12;
  localparam int OFF_W      = SPAN_W + FRAC_BITS;
  localparam int PCT_W      = 7;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_SPAN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_BASE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SPAN     = 3'd4;

  // reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd6554;
  localparam logic [BASE_W-1:0]  BASE_RST  = 12'd1100;
  localparam logic [SPAN_W-1:0]  SPAN_RST  = 12'd800;

  typedef struct packed {
    logic intensity_level;
    logic angle_level;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] intensity_percent;
    logic [OFF_W-1:0] angle_offset;
  } out_item_t;

endpackage

@@ rtl/rc_pulse_capture_filter_top.sv @@
// Channel | Valid       | Stall       | Payload
// --------+-------------+-------------+------------------------------------------
// in      | in_valid_i  | in_stall_o  | in_data_i  : intensity_level, angle_level
// out     | out_valid_o | out_stall_i | out_data_o : intensity_percent, angle_offset
// cfg     | cfg_we_i    | (none)      | cfg_idx_i, cfg_data_i
//
// A tick with no falling edge is taken in the idle state only. A tick with an
// angle falling edge only also runs the bit-serial alpha multiply (one alpha
// bit per cycle) and then the filter update. A tick with an intensity falling
// edge runs those, then clamp and scaling, the restoring divide (one quotient
// bit per cycle), and the load of the result, which waits while the output
// register still holds a stalled result.
// rst_ni is asynchronous, active low; counters and filters clear, config
// returns to its reset values.
// A stalled result waits in the output register; the next tick is taken as
// soon as that result has been loaded.
module rc_pulse_capture_filter_top
  import rcpcf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int NUM_W = OFF_W + PCT_W;   // holds offset * 100 + (span << 8) - 1
  localparam int DSH_W = OFF_W + PCT_W - 1;
  localparam int MUL_STEPS = ALPHA_W;
  localparam int CNT_W = $clog2(MUL_STEPS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_CLAMP = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PCT_W - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration
  logic [ALPHA_W-1:0] alpha_q;
  logic [BASE_W-1:0]  ibase_q, abase_q;
  logic [SPAN_W-1:0]  ispan_q, aspan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      ibase_q <= BASE_RST;
      ispan_q <= SPAN_RST;
      abase_q <= BASE_RST;
      aspan_q <= SPAN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FILTER_ALPHA:   alpha_q <= cfg_data_i[ALPHA_W-1:0];
        REG_INTENSITY_BASE: ibase_q <= cfg_data_i[BASE_W-1:0];
        REG_INTENSITY_SPAN: ispan_q <= cfg_data_i[SPAN_W-1:0];
        REG_ANGLE_BASE:     abase_q <= cfg_data_i[BASE_W-1:0];
        REG_ANGLE_SPAN:     aspan_q <= cfg_data_i[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // control and channel state
  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  iprev_q, iprev_d, aprev_q, aprev_d;
  logic [COUNT_BITS-1:0] icnt_q, icnt_d, acnt_q, acnt_d;
  logic [LPF_W-1:0]      ilpf_q, ilpf_d, alpf_q, alpf_d;
  logic                  ifell_q, ifell_d, afell_q, afell_d;
  logic                  out_valid_q, out_valid_d;

  // datapath
  logic [ALPHA_W-1:0] asr_q, asr_d;
  logic [LPF_W-1:0]   idiff_q, idiff_d, adiff_q, adiff_d;
  logic               ineg_q, ineg_d, aneg_q, aneg_d;
  logic [LPF_W-1:0]   ihi_q, ihi_d, ahi_q, ahi_d;
  logic [ALPHA_W-1:0] ilo_q, ilo_d, alo_q, alo_d;
  logic [OFF_W-1:0]   ioff_q, ioff_d, aoff_q, aoff_d;
  logic [NUM_W-1:0]   rem_q, rem_d;
  logic [DSH_W-1:0]   dsh_q, dsh_d;
  logic [PCT_W-1:0]   quo_q, quo_d;
  out_item_t          out_q, out_d;

  // combinational helpers
  logic             in_acc;
  logic             ifell, afell;
  logic [LPF_W-1:0] ix, ax;
  logic [LPF_W:0]   isum, asum;
  logic [LPF_W-1:0] istep, astep;
  logic [LPF_W-1:0] ib_ext, is_ext, ab_ext, as_ext, id, ad;
  logic [OFF_W-1:0] is_sh, as_sh;
  logic [NUM_W-1:0] off_ext, num;
  logic             ge;
  logic             out_load;

  assign in_acc = in_valid_i && !in_stall_o;
  assign ifell  = !in_data_i.intensity_level && iprev_q;
  assign afell  = !in_data_i.angle_level && aprev_q;
  assign ix     = {icnt_q, {FRAC_BITS{1'b0}}};
  assign ax     = {acnt_q, {FRAC_BITS{1'b0}}};

  // one shift-add step per alpha bit, LSB first
  assign isum  = {1'b0, ihi_q} + (asr_q[0] ? {1'b0, idiff_q} : '0);
  assign asum  = {1'b0, ahi_q} + (asr_q[0] ? {1'b0, adiff_q} : '0);
  // product >> 16, rounded half up
  assign istep = ihi_q + LPF_W'(ilo_q[ALPHA_W-1]);
  assign astep = ahi_q + LPF_W'(alo_q[ALPHA_W-1]);

  assign is_sh  = {ispan_q, {FRAC_BITS{1'b0}}};
  assign as_sh  = {aspan_q, {FRAC_BITS{1'b0}}};
  assign ib_ext = LPF_W'({ibase_q, {FRAC_BITS{1'b0}}});
  assign is_ext = LPF_W'(is_sh);
  assign ab_ext = LPF_W'({abase_q, {FRAC_BITS{1'b0}}});
  assign as_ext = LPF_W'(as_sh);
  assign id     = ilpf_q - ib_ext;
  assign ad     = alpf_q - ab_ext;

  // offset * 100 = offset * (64 + 32 + 4)
  assign off_ext = NUM_W'(ioff_q);
  assign num     = (off_ext << 6) + (off_ext << 5) + (off_ext << 2)
                 + NUM_W'(is_sh) - NUM_W'(1);
  assign ge      = rem_q >= {1'b0, dsh_q};

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iprev_d     = iprev_q;
    aprev_d     = aprev_q;
    icnt_d      = icnt_q;
    acnt_d      = acnt_q;
    ilpf_d      = ilpf_q;
    alpf_d      = alpf_q;
    ifell_d     = ifell_q;
    afell_d     = afell_q;
    out_valid_d = out_valid_q;
    asr_d       = asr_q;
    idiff_d     = idiff_q;
    adiff_d     = adiff_q;
    ineg_d      = ineg_q;
    aneg_d      = aneg_q;
    ihi_d       = ihi_q;
    ahi_d       = ahi_q;
    ilo_d       = ilo_q;
    alo_d       = alo_q;
    ioff_d      = ioff_q;
    aoff_d      = aoff_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // pulse width tracking
          iprev_d = in_data_i.intensity_level;
          if (in_data_i.intensity_level) begin
            if (!iprev_q) icnt_d = COUNT_BITS'(1);
            else if (icnt_q != COUNT_MAX) icnt_d = icnt_q + COUNT_BITS'(1);
          end else if (iprev_q) begin
            icnt_d = '0;
          end
          aprev_d = in_data_i.angle_level;
          if (in_data_i.angle_level) begin
            if (!aprev_q) acnt_d = COUNT_BITS'(1);
            else if (acnt_q != COUNT_MAX) acnt_d = acnt_q + COUNT_BITS'(1);
          end else if (aprev_q) begin
            acnt_d = '0;
          end
          ifell_d = ifell;
          afell_d = afell;
          ineg_d  = ix < ilpf_q;
          aneg_d  = ax < alpf_q;
          idiff_d = (ix < ilpf_q) ? ilpf_q - ix : ix - ilpf_q;
          adiff_d = (ax < alpf_q) ? alpf_q - ax : ax - alpf_q;
          asr_d   = alpha_q;
          ihi_d   = '0;
          ahi_d   = '0;
          cnt_d   = '0;
          if (ifell || afell) state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        ihi_d = isum[LPF_W:1];
        ilo_d = {isum[0], ilo_q[ALPHA_W-1:1]};
        ahi_d = asum[LPF_W:1];
        alo_d = {asum[0], alo_q[ALPHA_W-1:1]};
        asr_d = asr_q >> 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == MUL_LAST) state_d = ST_UPD;
      end
      ST_UPD: begin
        if (ifell_q) ilpf_d = ineg_q ? ilpf_q - istep : ilpf_q + istep;
        if (afell_q) alpf_d = aneg_q ? alpf_q - astep : alpf_q + astep;
        state_d = ifell_q ? ST_CLAMP : ST_IDLE;
      end
      ST_CLAMP: begin
        if (ilpf_q <= ib_ext) ioff_d = '0;
        else if (id > is_ext) ioff_d = is_sh;
        else ioff_d = id[OFF_W-1:0];
        if (alpf_q <= ab_ext) aoff_d = '0;
        else if (ad > as_ext) aoff_d = as_sh;
        else aoff_d = ad[OFF_W-1:0];
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        rem_d   = num;
        dsh_d   = {is_sh, {(PCT_W-1){1'b0}}};
        quo_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (ge) rem_d = rem_q - {1'b0, dsh_q};
        quo_d = {quo_q[PCT_W-2:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DIV_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          out_d.intensity_percent = (ispan_q == '0) ? '0 : quo_q;
          out_d.angle_offset      = aoff_q;
          out_valid_d             = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      iprev_q     <= 1'b0;
      aprev_q     <= 1'b0;
      icnt_q      <= '0;
      acnt_q      <= '0;
      ilpf_q      <= '0;
      alpf_q      <= '0;
      ifell_q     <= 1'b0;
      afell_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iprev_q     <= iprev_d;
      aprev_q     <= aprev_d;
      icnt_q      <= icnt_d;
      acnt_q      <= acnt_d;
      ilpf_q      <= ilpf_d;
      alpf_q      <= alpf_d;
      ifell_q     <= ifell_d;
      afell_q     <= afell_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asr_q   <= asr_d;
    idiff_q <= idiff_d;
    adiff_q <= adiff_d;
    ineg_q  <= ineg_d;
    aneg_q  <= aneg_d;
    ihi_q   <= ihi_d;
    ahi_q   <= ahi_d;
    ilo_q   <= ilo_d;
    alo_q   <= alo_d;
    ioff_q  <= ioff_d;
    aoff_q  <= aoff_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "rc_pulse_capture_filter_top_assert.svh"

  // partial product never exceeds the multiplicand
  `RCPCF_ASSERT_IMP(a_mul_bound, state_q == ST_MUL, ihi_q <= idiff_q && ahi_q <= adiff_q)
  // divider runs exactly one step per quotient bit
  `RCPCF_ASSERT_IMP(a_div_count, state_q == ST_DIV, cnt_q <= DIV_LAST)
  // a new result only appears out of the final state
  `RCPCF_ASSERT_NXT(a_out_src, !out_valid_o && state_q != ST_DONE, !out_valid_o)

endmodule

@@ verif/rc_pulse_capture_filter_top_tb.sv @@
`timescale 1ns / 100ps

module rc_pulse_capture_filter_top_tb;
  import rcpcf_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 64;    // quiet time in drain() after the last reading is back
  localparam int unsigned HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int unsigned RANDOM_TICKS  = 1150;
  localparam int unsigned MAX_REPORTS   = 10;

  // indexes past the register file; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

  typedef struct packed {
    logic                  fell;
    logic [COUNT_BITS-1:0] count;
    logic [COUNT_BITS-1:0] width;
  } chan_step_t;

  // run-length limits of one pin's pattern, in ticks
  typedef struct {
    int unsigned hi_min;
    int unsigned hi_max;
    int unsigned lo_min;
    int unsigned lo_max;
  } pulse_shape_t;

  // Keeps its own copy of the capture/filter state, predicts one reading per
  // intensity falling edge and checks readings in order.
  class capture_scoreboard;
    logic [ALPHA_W-1:0]    alpha;
    logic [BASE_W-1:0]     i_base, a_base;
    logic [SPAN_W-1:0]     i_span, a_span;
    logic                  i_prev, a_prev;
    logic [COUNT_BITS-1:0] i_count, a_count;
    logic [LPF_W-1:0]      i_lpf, a_lpf;
    out_item_t             pending_readings[$];
    int unsigned           errors;

    function new();
      alpha   = ALPHA_RST;
      i_base  = BASE_RST;
      a_base  = BASE_RST;
      i_span  = SPAN_RST;
      a_span  = SPAN_RST;
      i_prev  = 1'b0;
      a_prev  = 1'b0;
      i_count = '0;
      a_count = '0;
      i_lpf   = '0;
      a_lpf   = '0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FILTER_ALPHA:   alpha  = val[ALPHA_W-1:0];
        REG_INTENSITY_BASE: i_base = val[BASE_W-1:0];
        REG_INTENSITY_SPAN: i_span = val[SPAN_W-1:0];
        REG_ANGLE_BASE:     a_base = val[BASE_W-1:0];
        REG_ANGLE_SPAN:     a_span = val[SPAN_W-1:0];
        default: ;
      endcase
    endfunction

    // rising tick loads 1, high ticks count up and saturate, falling tick
    // hands out the width and clears
    function chan_step_t track(logic lvl, logic prev, logic [COUNT_BITS-1:0] cnt);
      chan_step_t r;
      r.fell  = 1'b0;
      r.width = '0;
      r.count = cnt;
      if (lvl) begin
        if (!prev) r.count = COUNT_BITS'(1);
        else if (cnt != '1) r.count = cnt + 1'b1;
      end else if (prev) begin
        r.fell  = 1'b1;
        r.width = cnt;
        r.count = '0;
      end
      return r;
    endfunction

    // step magnitude rounded half up, applied toward the new sample
    function logic [LPF_W-1:0] lowpass(logic [LPF_W-1:0] lpf, logic [COUNT_BITS-1:0] width);
      logic [63:0] x, acc;
      x = 64'(width) << FRAC_BITS;
      if (x >= 64'(lpf)) begin
        acc = 64'(lpf) + ((64'(alpha) * (x - 64'(lpf)) + 64'h8000) >> 16);
      end else begin
        acc = 64'(lpf) - ((64'(alpha) * (64'(lpf) - x) + 64'h8000) >> 16);
      end
      return acc[LPF_W-1:0];
    endfunction

    function logic [OFF_W-1:0] clamp_offset(logic [LPF_W-1:0] lpf, logic [BASE_W-1:0] base,
                                            logic [SPAN_W-1:0] span);
      logic [63:0] b, s, d;
      b = 64'(base) << FRAC_BITS;
      s = 64'(span) << FRAC_BITS;
      if (64'(lpf) <= b) begin
        d = '0;
      end else begin
        d = 64'(lpf) - b;
        if (d > s) d = s;
      end
      return d[OFF_W-1:0];
    endfunction

    // one accepted input transaction
    function void capture_tick(in_item_t it);
      chan_step_t  ic, ac;
      out_item_t   r;
      logic [63:0] ioff, s;
      ic = track(it.intensity_level, i_prev, i_count);
      ac = track(it.angle_level, a_prev, a_count);
      i_prev  = it.intensity_level;
      a_prev  = it.angle_level;
      i_count = ic.count;
      a_count = ac.count;
      // both filters move before the reading is formed
      if (ic.fell) i_lpf = lowpass(i_lpf, ic.width);
      if (ac.fell) a_lpf = lowpass(a_lpf, ac.width);
      if (ic.fell) begin
        ioff = 64'(clamp_offset(i_lpf, i_base, i_span));
        s    = 64'(i_span) << FRAC_BITS;
        r.intensity_percent = (s == 0) ? '0 : PCT_W'((ioff * 100 + s - 1) / s);
        r.angle_offset      = clamp_offset(a_lpf, a_base, a_span);
        pending_readings.push_back(r);
      end
    endfunction

    // one accepted output transaction
    function void check_reading(out_item_t got);
      out_item_t want;
      if (pending_readings.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected reading: pct %0d offset %0d", got.intensity_percent,
                   got.angle_offset);
      end else begin
        want = pending_readings.pop_front();
        if (want.intensity_percent !== got.intensity_percent ||
            want.angle_offset !== got.angle_offset) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("reading mismatch: pct exp %0d got %0d, offset exp %0d got %0d",
                     want.intensity_percent, got.intensity_percent,
                     want.angle_offset, got.angle_offset);
        end
      end
    endfunction
  endclass

  logic                 clk_i     = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  out_item_t            out_data_o;

  capture_scoreboard sb = new();

  int unsigned cycles   = 0;
  int unsigned hold_seq = 0;    // bumped to ask the receiver for a long hold-off
  bit          steady_tx = 1'b0;

  // pattern generator state, one per pin
  logic        i_lvl  = 1'b0;
  logic        a_lvl  = 1'b0;
  int unsigned i_left = 0;
  int unsigned a_left = 0;

  always #6 clk_i = ~clk_i;

  rc_pulse_capture_filter_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(80, 30);
  endfunction

  function automatic logic next_level(inout logic lvl, inout int unsigned left,
                                      input pulse_shape_t sh);
    if (left == 0) begin
      lvl  = ~lvl;
      left = lvl ? $urandom_range(sh.hi_max, sh.hi_min) : $urandom_range(sh.lo_max, sh.lo_min);
    end
    left--;
    return lvl;
  endfunction

  // one input transaction; returns at the edge that accepts it
  task automatic send_tick(input logic il, input logic al);
    int unsigned gap;
    in_item_t    it;
    gap = steady_tx ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.intensity_level = il;
    it.angle_level     = al;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic send_run(input logic il, input logic al, input int unsigned n);
    repeat (n) send_tick(il, al);
  endtask

  task automatic run_ticks(input int unsigned n, input pulse_shape_t ish,
                           input pulse_shape_t ash, input int unsigned noise_pct);
    logic il, al;
    for (int unsigned k = 0; k < n; k++) begin
      il = next_level(i_lvl, i_left, ish);
      al = next_level(a_lvl, a_left, ash);
      // noise: random glitch levels on top of the pulse train
      if ($urandom_range(99, 0) < noise_pct) il = 1'($urandom);
      if ($urandom_range(99, 0) < noise_pct) al = 1'($urandom);
      send_tick(il, al);
    end
  endtask

  // stop offering, let every reading come back, then let the core settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // 12-bit registers get random junk above their width
  task automatic apply_cfg(input logic [ALPHA_W-1:0] al, input logic [BASE_W-1:0] ib,
                           input logic [SPAN_W-1:0] isp, input logic [BASE_W-1:0] ab,
                           input logic [SPAN_W-1:0] asp);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    write_reg(REG_FILTER_ALPHA, al);
    write_reg(REG_INTENSITY_BASE, {junk[CFG_W-1:BASE_W], ib});
    junk = CFG_W'($urandom);
    write_reg(REG_INTENSITY_SPAN, {junk[CFG_W-1:SPAN_W], isp});
    junk = CFG_W'($urandom);
    write_reg(REG_ANGLE_BASE, {junk[CFG_W-1:BASE_W], ab});
    junk = CFG_W'($urandom);
    write_reg(REG_ANGLE_SPAN, {junk[CFG_W-1:SPAN_W], asp});
  endtask

  function automatic logic [SPAN_W-1:0] pick_span();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 5) return '0;
    if (r < 15) return SPAN_W'(1);
    return SPAN_W'($urandom_range(40, 1));
  endfunction

  // small bases and spans so short pulses land inside the mapped range
  task automatic random_cfg(output pulse_shape_t ish, output pulse_shape_t ash);
    logic [ALPHA_W-1:0] al;
    logic [BASE_W-1:0]  ib, ab;
    logic [SPAN_W-1:0]  isp, asp;
    int unsigned        r;
    r = $urandom_range(99, 0);
    if (r < 5) al = '0;
    else if (r < 15) al = ALPHA_W'(1);
    else if (r < 40) al = '1;
    else al = ALPHA_W'($urandom_range(65535, 1));
    ib  = ($urandom_range(9, 0) == 0) ? '0 : BASE_W'($urandom_range(40, 0));
    ab  = ($urandom_range(9, 0) == 0) ? '0 : BASE_W'($urandom_range(40, 0));
    isp = pick_span();
    asp = pick_span();
    apply_cfg(al, ib, isp, ab, asp);
    ish.hi_min = 1;
    ish.hi_max = 32'(ib) + 32'(isp) + 8;
    ish.lo_min = 1;
    ish.lo_max = $urandom_range(30, 1);
    ash.hi_min = 1;
    ash.hi_max = 32'(ab) + 32'(asp) + 8;
    ash.lo_min = 1;
    ash.lo_max = $urandom_range(30, 1);
  endtask

  // sample both channels at the edge; transactions are counted here only
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_stall_o === 1'b0) sb.capture_tick(in_data);
      if (out_valid_o === 1'b1 && !out_stall) sb.check_reading(out_data_o);
    end
  end

  // receiver: random stalls, quiet stretches, and a long hold-off on request
  initial begin : receiver
    int unsigned stall_left, free_left, hold_left, seen_hold;
    logic        s;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    seen_hold  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        s = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        s = 1'b1;
      end else if (free_left != 0) begin
        free_left--;
        s = 1'b0;
      end else begin
        stall_left = pick_gap();
        free_left  = ($urandom_range(15, 0) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(10, 0);
        s = 1'b0;
      end
      out_stall <= s;
    end
  end

  initial begin : watchdog
    while (cycles < LIMIT_CYCLES) @(posedge clk_i) cycles++;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    pulse_shape_t ish, ash;
    int unsigned  rand_ticks, n, noise;
    rand_ticks = 0;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of every register, edge corner cases
    apply_cfg('1, '0, '1, '0, '1);
    send_run(1'b1, 1'b1, 4);          // both pins high on the first tick after reset
    send_tick(1'b0, 1'b0);            // both fall together
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);            // intensity alone
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);            // angle falls alone, intensity rises
    send_tick(1'b0, 1'b0);
    drain();
    apply_cfg('0, '0, '0, '0, '0);    // frozen filter, zero spans
    send_run(1'b1, 1'b1, 2);
    send_tick(1'b0, 1'b0);
    drain();
    apply_cfg(ALPHA_W'(1), '1, SPAN_W'(1), '1, SPAN_W'(1));
    send_run(1'b1, 1'b1, 2);
    send_tick(1'b0, 1'b0);
    drain();
    for (int k = int'(REG_NONE_LO); k <= int'(REG_NONE_HI); k++)
      write_reg(CFG_IDX_W'(k), CFG_W'($urandom));
    send_run(1'b1, 1'b0, 3);
    send_tick(1'b0, 1'b0);
    drain();

    // back-pressure: receiver holds off while short pulses keep arriving
    steady_tx = 1'b1;
    apply_cfg('1, '0, 3, '0, 3);
    ish = '{hi_min: 1, hi_max: 3, lo_min: 1, lo_max: 3};
    ash = '{hi_min: 1, hi_max: 5, lo_min: 1, lo_max: 3};
    hold_seq <= hold_seq + 1;
    run_ticks(300, ish, ash, 0);
    steady_tx = 1'b0;
    drain();

    // random phases with fresh settings each time
    while (rand_ticks < RANDOM_TICKS) begin
      random_cfg(ish, ash);
      noise     = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 1) : 0;
      steady_tx = ($urandom_range(5, 0) == 0);
      if ($urandom_range(9, 0) == 0) hold_seq <= hold_seq + 1;
      n = $urandom_range(300, 80);
      run_ticks(n, ish, ash, noise);
      rand_ticks += n;
      drain();
    end

    if (sb.pending_readings.size() != 0)
      $display("%0d readings never arrived", sb.pending_readings.size());
    if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rcpcf_pkg.sv
rtl/rc_pulse_capture_filter_top.sv
verif/rc_pulse_capture_filter_top_tb.sv
